// File: hdl/xomse_pkg.sv
// Types, codes and register number tables for the x86-64 ModRM/SIB operand encoder.
package xomse_pkg;

	localparam logic [2:0] FORM_E = 3'd0;
	localparam logic [2:0] FORM_M = 3'd1;
	localparam logic [2:0] FORM_R = 3'd2;
	localparam logic [2:0] FORM_W = 3'd3;
	localparam logic [2:0] FORM_G = 3'd4;

	localparam logic [1:0] KIND_REG = 2'd0;
	localparam logic [1:0] KIND_MEM = 2'd1;

	localparam logic [1:0] RMODE_FULL  = 2'd1;
	localparam logic [1:0] RMODE_HIGH  = 2'd2;

	localparam logic [4:0] REG_RSP  = 5'd7;
	localparam logic [4:0] REG_R12  = 5'd12;
	localparam logic [4:0] REG_NONE = 5'd16;
	localparam logic [4:0] REG_RIP  = 5'd17;

	localparam logic [3:0] RM_SIB      = 4'd4;
	localparam logic [3:0] RM_DISP32   = 4'd5;
	localparam logic [3:0] SIB_NO_IDX  = 4'd4;
	localparam logic [3:0] SIB_NO_BASE = 4'd5;

	localparam logic [1:0] MOD_NODISP = 2'd0;
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_DISP32 = 2'd2;
	localparam logic [1:0] MOD_REG    = 2'd3;

	localparam logic [3:0] HW_REGS [16] = '{
		4'd0, 4'd3, 4'd1, 4'd2, 4'd6, 4'd7, 4'd5, 4'd4,
		4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14, 4'd15
	};
	localparam logic [3:0] HW_HIBYTE [4] = '{4'd4, 4'd7, 4'd5, 4'd6};

	typedef enum logic [2:0] {
		ERR_OK       = 3'd0,
		ERR_KIND     = 3'd1,
		ERR_DISPSIZE = 3'd2,
		ERR_RSP_IDX  = 3'd3,
		ERR_BAD_REG  = 3'd4
	} err_code_t;

	typedef struct packed {
		logic [2:0]  req_type;
		logic [1:0]  operand_kind;
		logic [1:0]  reg_mode;
		logic        wide_mode;
		logic        mem_is_8_bytes;
		logic [4:0]  base_reg;
		logic [4:0]  index_reg;
		logic [1:0]  scale;
		logic [3:0]  disp_size;
		logic signed [31:0] displacement;
		logic [31:0] instr_address;
		logic [3:0]  instr_size;
	} op_word_t;

	typedef struct packed {
		logic [1:0]  mod_field;
		logic [3:0]  reg_field;
		logic [3:0]  rm_field;
		logic [1:0]  sib_scale;
		logic [3:0]  sib_index;
		logic [3:0]  sib_base;
		logic        has_sib;
		logic signed [31:0] disp_value;
		logic [2:0]  disp_bytes;
		logic        rex_w;
		err_code_t   error_code;
	} enc_word_t;

endpackage

// File: hdl/xomse_core.sv
// Combinational ModRM/SIB encoding of one operand word.
module xomse_core import xomse_pkg::*; (
	input  op_word_t  op,
	output enc_word_t enc
);

	logic [3:0]  hw_base;
	logic [3:0]  reg_num;
	logic        sib;
	logic        based;
	logic [31:0] disp;
	logic [31:0] next_addr;
	err_code_t   err;
	enc_word_t   r;

	assign hw_base   = HW_REGS[op.base_reg[3:0]];
	assign next_addr = op.instr_address + {28'd0, op.instr_size};
	assign sib   = (op.index_reg != REG_NONE) || (op.base_reg == REG_RSP)
		|| (op.base_reg == REG_R12);
	assign based = op.base_reg < REG_NONE;

	always_comb begin
		r       = '0;
		err     = ERR_OK;
		reg_num = '0;
		disp    = op.displacement;
		if (op.req_type > FORM_G || op.operand_kind > KIND_MEM) begin
			err = ERR_KIND;
		end else if (op.operand_kind == KIND_REG) begin
			if (op.req_type == FORM_M) begin
				err = ERR_KIND;
			end else if (op.base_reg > 5'd15) begin
				err = ERR_BAD_REG;
			end else if (op.req_type == FORM_W) begin
				reg_num = op.base_reg[3:0];
			end else if (op.reg_mode == RMODE_HIGH) begin
				if (op.base_reg > 5'd3) begin
					err = ERR_BAD_REG;
				end else begin
					reg_num = HW_HIBYTE[op.base_reg[1:0]];
				end
			end else begin
				reg_num = hw_base;
			end
			if (op.req_type == FORM_G) begin
				r.reg_field = reg_num;
			end else begin
				r.mod_field = MOD_REG;
				r.rm_field  = reg_num;
			end
			r.rex_w = (op.req_type != FORM_W) && op.wide_mode
				&& (op.reg_mode == RMODE_FULL);
		end else begin
			if (op.req_type == FORM_R || op.req_type == FORM_G) begin
				err = ERR_KIND;
			end else if (op.index_reg > REG_NONE || op.base_reg > REG_RIP) begin
				err = ERR_BAD_REG;
			end else if (op.index_reg == REG_RSP) begin
				err = ERR_RSP_IDX;
			end else if (sib && op.base_reg == REG_RIP) begin
				err = ERR_BAD_REG;
			end else if (based && op.disp_size != 4'd0 && op.disp_size != 4'd1
					&& op.disp_size != 4'd4) begin
				err = ERR_DISPSIZE;
			end else if (!based && op.disp_size != 4'd4) begin
				err = ERR_DISPSIZE;
			end
			r.disp_bytes = op.disp_size[2:0];
			if (based) begin
				unique case (op.disp_size)
					4'd0:    r.mod_field = MOD_NODISP;
					4'd1:    r.mod_field = MOD_DISP8;
					default: r.mod_field = MOD_DISP32;
				endcase
				if (op.disp_size == 4'd0 && hw_base[2:0] == 3'd5) begin
					// rbp and r13 have no mod 0 form; use a zero disp8.
					r.mod_field  = MOD_DISP8;
					r.disp_bytes = 3'd1;
					disp         = '0;
				end
			end
			if (sib) begin
				r.rm_field  = RM_SIB;
				r.has_sib   = 1'b1;
				r.sib_scale = op.scale;
				r.sib_index = (op.index_reg == REG_NONE) ? SIB_NO_IDX
					: HW_REGS[op.index_reg[3:0]];
				if (based) begin
					r.sib_base = hw_base;
				end else begin
					r.mod_field = MOD_NODISP;
					r.sib_base  = SIB_NO_BASE;
				end
			end else if (!based) begin
				r.mod_field = MOD_NODISP;
				r.rm_field  = RM_DISP32;
				if (op.base_reg == REG_NONE) begin
					disp = op.displacement - next_addr;
				end
			end else begin
				r.rm_field = hw_base;
			end
			r.disp_value = (r.disp_bytes == 3'd0) ? '0 : disp;
			r.rex_w = (op.req_type == FORM_E) && op.wide_mode && op.mem_is_8_bytes;
		end
		if (err != ERR_OK) begin
			r = '0;
		end
		r.error_code = err;
		enc = r;
	end

endmodule

// File: hdl/x86_64_operand_modrm_sib_encoder_unit.sv
// Top level of the x86-64 ModRM/SIB operand encoder: input register, encoder, result register.
//
// Takes one operand description word per cycle while the output is not stalled and
// presents one encoded word (ModRM mod/reg/rm, SIB, displacement, REX.W and an error
// code) from the result register, after the word has passed through the input register
// and the encoder logic. The block is fully pipelined: one input register, the encoder
// logic, and one result register, so a new word is accepted every cycle while results
// are being taken. There is no configuration and no state beyond the two pipeline
// registers.
module x86_64_operand_modrm_sib_encoder_unit import xomse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      op_valid,
	output logic      op_ready,
	input  op_word_t  op,
	output logic      enc_valid,
	input  logic      enc_ready,
	output enc_word_t enc
);

	op_word_t  op_s1;
	logic      valid_s1;
	logic      ready_s2;
	enc_word_t enc_comb;
	enc_word_t enc_s2;
	logic      valid_s2;

	assign ready_s2 = !valid_s2 || enc_ready;
	assign op_ready = !valid_s1 || ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (op_ready) begin
			valid_s1 <= op_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op_ready && op_valid) begin
			op_s1 <= op;
		end
	end

	xomse_core u_core (
		.op  (op_s1),
		.enc (enc_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			enc_s2 <= enc_comb;
		end
	end

	assign enc_valid = valid_s2;
	assign enc       = enc_s2;

	a_err_clears: assert property (@(posedge clk) disable iff (!arst_n)
		enc_valid && enc.error_code != ERR_OK |-> enc.mod_field == 2'd0
			&& enc.rm_field == 4'd0 && enc.reg_field == 4'd0 && !enc.has_sib
			&& enc.disp_bytes == 3'd0 && !enc.rex_w)
		else $error("error result carries nonzero fields");

	a_no_sib_fields: assert property (@(posedge clk) disable iff (!arst_n)
		enc_valid && !enc.has_sib |-> enc.sib_scale == 2'd0
			&& enc.sib_index == 4'd0 && enc.sib_base == 4'd0)
		else $error("SIB fields set without SIB byte");

	a_disp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		enc_valid && enc.disp_bytes == 3'd0 |-> enc.disp_value == 32'sd0)
		else $error("displacement value without displacement bytes");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(op_s1))
		else $error("input stage lost a word while stalled");

endmodule
